// ===== src/svf_pkg.sv =====
// ----------------------------------------------------------------------------
// svf_pkg: shared definitions for the state variable filter
// Register indexes, filter mode codes, coefficient widths and the default
// values of the top-level parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package svf_pkg;

    // Default values of the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int STATE_WIDTH_DEF    = 32;

    // Fraction bits that a sample gains when it enters the integrators.
    localparam int STATE_FRAC_BITS = 8;

    // Configuration register widths.
    localparam int MODE_W     = 2;
    localparam int FREQ_W     = 17;
    localparam int DAMP_W     = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // The serial multiplier takes the wider of the two coefficients.
    localparam int COEF_W = (FREQ_W > DAMP_W) ? FREQ_W : DAMP_W;

    // Reset value of the damping coefficient: 1.0 with 16 fraction bits.
    localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(65536);

    typedef enum logic [MODE_W-1:0] {
        MODE_BYPASS = 2'd0,
        MODE_LOW    = 2'd1,
        MODE_HIGH   = 2'd2,
        MODE_BAND   = 2'd3
    } mode_t;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd2;

endpackage

`default_nettype wire

// ===== src/state_variable_filter_top.sv =====
// ----------------------------------------------------------------------------
// state_variable_filter_top: Chamberlin state variable filter
// Two saturating integrators updated once per filtered sample through a single
// bit-serial coefficient multiplier; lowpass, highpass, bandpass or bypass output.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                      Payload
//  --------  ---------  -------------------------  ---------------------------
//  input     in         s_tvalid/s_tready/s_tdata  sample_in (signed)
//  result    out        m_tvalid/m_tready/m_tdata  sample_out (signed)
//  config    in         cfg_we/cfg_index/cfg_wdata filter_mode, frequency_coeff,
//                                                  damping_coeff
//
//  The filter takes a new input sample only once the previous one has been
//  handed to the output register. N = max(19, COEF_FRAC_BITS) is the number
//  of steps of the bit-serial multiplier; the three products run one after
//  another on that multiplier. In bypass mode a sample skips the multiplier
//  and goes straight to the output stage. Reset (aresetn low at a clock edge)
//  clears both integrators and loads the register reset values. A stalled
//  result waits in the output register; the next sample is still accepted
//  and processed, and its own result waits until that register is free.
//
`default_nettype none

module state_variable_filter_top
    import svf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int STATE_WIDTH    = STATE_WIDTH_DEF,
    localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Input sample channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,    // sample_in from bit 0, zero padded

    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,    // sample_out from bit 0, zero padded

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Number of multiplier steps: every coefficient bit is consumed, and at
    // least COEF_FRAC_BITS product bits are shifted out below the accumulator.
    localparam int N     = (COEF_W > COEF_FRAC_BITS) ? COEF_W : COEF_FRAC_BITS;
    localparam int CNT_W = $clog2(N);
    localparam int S     = STATE_WIDTH;
    // Full product width, and the width of the product after rounding.
    localparam int PW    = S + N;
    localparam int RW    = PW - COEF_FRAC_BITS;
    // Working width for sums before saturation; wide enough for the rounded
    // product, a scaled sample and an integrator with headroom.
    localparam int EW0   = (RW > SAMPLE_WIDTH + STATE_FRAC_BITS) ?
                           RW : (SAMPLE_WIDTH + STATE_FRAC_BITS);
    localparam int EW    = ((EW0 > S) ? EW0 : S) + 3;

    localparam logic signed [EW-1:0] ST_MAX = EW'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] ST_MIN = EW'(-(64'sd1 <<< (S - 1)));
    localparam logic signed [EW-1:0] SM_MAX =
        EW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SM_MIN = EW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,   // waiting for an input transfer
        ST_MUL  = 6'b000010,   // one coefficient bit per cycle
        ST_RND  = 6'b000100,   // round the product
        ST_UPD  = 6'b001000,   // update low, high or band
        ST_FIN  = 6'b010000,   // select, round and clamp the output
        ST_OUT  = 6'b100000    // hand the result to the output register
    } state_t;

    // Which of the three products is in the multiplier.
    typedef enum logic [2:0] {
        PH_LOW  = 3'b001,      // f * band, feeds the lowpass integrator
        PH_HIGH = 3'b010,      // q * band, feeds the highpass term
        PH_BAND = 3'b100       // f * high, feeds the bandpass integrator
    } phase_t;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    mode_t                    mode_reg, mode_next;
    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic [DAMP_W-1:0]        damp_reg, damp_next;

    logic signed [S-1:0]      low_reg, low_next;
    logic signed [S-1:0]      band_reg, band_next;
    logic signed [S-1:0]      high_reg, high_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic signed [EW-1:0]     base_reg, base_next;
    logic signed [EW-1:0]     rnd_reg, rnd_next;
    logic signed [SAMPLE_WIDTH-1:0] res_reg, res_next;

    // Bit-serial multiplier: coefficient shift register, parallel multiplicand,
    // accumulator and the shift register that collects the low product bits.
    logic [COEF_W-1:0]        coef_reg, coef_next;
    logic signed [S-1:0]      v_reg, v_next;
    logic signed [S-1:0]      acc_reg, acc_next;
    logic [N-1:0]             lsb_reg, lsb_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    logic signed [S:0]        step_sum;
    logic [PW-1:0]            prod_full;
    logic signed [RW-1:0]     prod_top;
    logic signed [S-1:0]      high_sat;
    logic signed [S-1:0]      sel;
    logic signed [EW-1:0]     sel_ext;
    logic signed [EW-1:0]     out_ext;

    function automatic logic signed [S-1:0] sat_state(input logic signed [EW-1:0] v);
        logic signed [S-1:0] r;
        if (v > ST_MAX) begin
            r = ST_MAX[S-1:0];
        end else if (v < ST_MIN) begin
            r = ST_MIN[S-1:0];
        end else begin
            r = v[S-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [EW-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v > SM_MAX) begin
            r = SM_MAX[SAMPLE_WIDTH-1:0];
        end else if (v < SM_MIN) begin
            r = SM_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // One multiplier step: add the multiplicand when the current coefficient
    // bit is set, then shift the sum right by one. The bit that drops out is
    // a product bit and moves into the low shift register. The accumulator
    // always stays within the multiplicand's range, so S bits hold it.
    assign step_sum = {acc_reg[S-1], acc_reg} + (coef_reg[0] ? {v_reg[S-1], v_reg} : '0);

    // After N steps the product is {acc, lsb}. Dropping COEF_FRAC_BITS bits
    // with round half up is the floor of the shift plus the highest dropped bit.
    assign prod_full = {acc_reg, lsb_reg};
    assign prod_top  = prod_full[PW-1:COEF_FRAC_BITS];

    assign high_sat  = sat_state(base_reg - rnd_reg);

    always_comb begin
        unique case (mode_reg)
            MODE_LOW:  sel = low_reg;
            MODE_HIGH: sel = high_reg;
            default:   sel = band_reg;
        endcase
    end

    assign sel_ext = EW'(sel);
    // Drop the state fraction bits, rounding half up. The rounding bit is kept
    // signed so that the shift stays arithmetic.
    assign out_ext = (sel_ext >>> STATE_FRAC_BITS)
                   + $signed({{(EW-1){1'b0}}, sel[STATE_FRAC_BITS-1]});

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        mode_next     = mode_reg;
        freq_next     = freq_reg;
        damp_next     = damp_reg;
        low_next      = low_reg;
        band_next     = band_reg;
        high_next     = high_reg;
        x_next        = x_reg;
        rnd_next      = rnd_reg;
        res_next      = res_reg;
        coef_next     = coef_reg;
        v_next        = v_reg;
        acc_next      = acc_reg;
        lsb_next      = lsb_reg;
        cnt_next      = cnt_reg;
        m_tdata_next  = m_tdata_reg;
        // The scaled sample minus the new lowpass value; it settles during
        // the damping product, while both operands stay put.
        base_next     = (EW'(x_reg) <<< STATE_FRAC_BITS) - EW'(low_reg);
        // A waiting result leaves when the downstream side takes it.
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        // Configuration writes must arrive only while the filter is idle; the block itself does not enforce this.
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE: mode_next = mode_t'(cfg_wdata[MODE_W-1:0]);
                REG_FREQ: freq_next = cfg_wdata[FREQ_W-1:0];
                REG_DAMP: damp_next = cfg_wdata[DAMP_W-1:0];
                default:  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next = s_tdata[SAMPLE_WIDTH-1:0];
                    if (mode_reg == MODE_BYPASS) begin
                        // Bypass passes the sample through and leaves the
                        // integrators alone.
                        res_next   = s_tdata[SAMPLE_WIDTH-1:0];
                        state_next = ST_OUT;
                    end else begin
                        coef_next  = COEF_W'(freq_reg);
                        v_next     = band_reg;
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_LOW;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL: begin
                acc_next  = step_sum[S:1];
                lsb_next  = {step_sum[0], lsb_reg[N-1:1]};
                coef_next = coef_reg >> 1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N - 1)) begin
                    state_next = ST_RND;
                end
            end

            ST_RND: begin
                rnd_next   = EW'(prod_top)
                           + $signed({{(EW-1){1'b0}}, prod_full[COEF_FRAC_BITS-1]});
                state_next = ST_UPD;
            end

            ST_UPD: begin
                acc_next = '0;
                cnt_next = '0;
                unique case (phase_reg)
                    PH_LOW: begin
                        low_next   = sat_state(EW'(low_reg) + rnd_reg);
                        coef_next  = COEF_W'(damp_reg);
                        v_next     = band_reg;
                        phase_next = PH_HIGH;
                        state_next = ST_MUL;
                    end
                    PH_HIGH: begin
                        high_next  = high_sat;
                        coef_next  = COEF_W'(freq_reg);
                        v_next     = high_sat;
                        phase_next = PH_BAND;
                        state_next = ST_MUL;
                    end
                    default: begin
                        band_next  = sat_state(EW'(band_reg) + rnd_reg);
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_FIN: begin
                res_next   = sat_sample(out_ext);
                state_next = ST_OUT;
            end

            default: begin
                // Load the output register once its previous result is gone.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'($unsigned(res_reg));
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_LOW;
            mode_reg     <= MODE_BYPASS;
            freq_reg     <= '0;
            damp_reg     <= DAMP_RESET;
            low_reg      <= '0;
            band_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            mode_reg     <= mode_next;
            freq_reg     <= freq_next;
            damp_reg     <= damp_next;
            low_reg      <= low_next;
            band_reg     <= band_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        high_reg    <= high_next;
        x_reg       <= x_next;
        base_reg    <= base_next;
        rnd_reg     <= rnd_next;
        res_reg     <= res_next;
        coef_reg    <= coef_next;
        v_reg       <= v_next;
        acc_reg     <= acc_next;
        lsb_reg     <= lsb_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
